>>> rtl/core/u2e_pkg.sv
// ----------------------------------------------------------------------------
// u2e_pkg
// Shared constants and the named entity lookup for the entity encoder.
// ----------------------------------------------------------------------------
package u2e_pkg;

    localparam int CodeW    = 16;
    localparam int ByteW    = 8;
    localparam int RunMax   = 8;
    localparam int NameMax  = 6;
    localparam int DigitMax = 5;

    localparam logic [ByteW-1:0] ChAmp  = 8'h26;
    localparam logic [ByteW-1:0] ChHash = 8'h23;
    localparam logic [ByteW-1:0] ChSemi = 8'h3B;
    localparam logic [ByteW-1:0] ChZero = 8'h30;
    localparam logic [ByteW-1:0] ChNul  = 8'h00;
    localparam logic [CodeW-1:0] CodeLf = 16'h000A;
    localparam logic [CodeW-1:0] CodeCr = 16'h000D;
    localparam logic [CodeW-1:0] CodeLo = 16'h0020;
    localparam logic [CodeW-1:0] CodeHi = 16'h007E;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_END    = 1'b1;

    typedef logic [ByteW-1:0] byte_t;
    typedef logic [NameMax*ByteW-1:0] name_t;

    // Name text, last character in the low byte, unused bytes zero.
    function automatic name_t name_lookup(input logic [CodeW-1:0] c);
        name_t n;
        n = '0;
        case (c)
            16'd34: n = "quot";     16'd38: n = "amp";      16'd60: n = "lt";
            16'd62: n = "gt";       16'd160: n = "nbsp";    16'd161: n = "iexcl";
            16'd162: n = "cent";    16'd163: n = "pound";   16'd164: n = "curren";
            16'd165: n = "yen";     16'd166: n = "brvbar";  16'd167: n = "sect";
            16'd168: n = "uml";     16'd169: n = "copy";    16'd170: n = "ordf";
            16'd171: n = "laquo";   16'd172: n = "not";     16'd173: n = "shy";
            16'd174: n = "reg";     16'd175: n = "macr";    16'd176: n = "deg";
            16'd177: n = "plusmn";  16'd178: n = "sup2";    16'd179: n = "sup3";
            16'd180: n = "acute";   16'd181: n = "micro";   16'd182: n = "para";
            16'd183: n = "middot";  16'd184: n = "cedil";   16'd185: n = "sup1";
            16'd186: n = "ordm";    16'd187: n = "raquo";   16'd188: n = "frac14";
            16'd189: n = "frac12";  16'd190: n = "frac34";  16'd191: n = "iquest";
            16'd192: n = "Agrave";  16'd193: n = "Aacute";  16'd194: n = "Acirc";
            16'd195: n = "Atilde";  16'd196: n = "Auml";    16'd197: n = "Aring";
            16'd198: n = "AElig";   16'd199: n = "Ccedil";  16'd200: n = "Egrave";
            16'd201: n = "Eacute";  16'd202: n = "Ecirc";   16'd203: n = "Euml";
            16'd204: n = "Igrave";  16'd205: n = "Iacute";  16'd206: n = "Icirc";
            16'd207: n = "Iuml";    16'd208: n = "ETH";     16'd209: n = "Ntilde";
            16'd210: n = "Ograve";  16'd211: n = "Oacute";  16'd212: n = "Ocirc";
            16'd213: n = "Otilde";  16'd214: n = "Ouml";    16'd215: n = "times";
            16'd216: n = "Oslash";  16'd217: n = "Ugrave";  16'd218: n = "Uacute";
            16'd219: n = "Ucirc";   16'd220: n = "Uuml";    16'd221: n = "Yacute";
            16'd222: n = "THORN";   16'd223: n = "szlig";   16'd224: n = "agrave";
            16'd225: n = "aacute";  16'd226: n = "acirc";   16'd227: n = "atilde";
            16'd228: n = "auml";    16'd229: n = "aring";   16'd230: n = "aelig";
            16'd231: n = "ccedil";  16'd232: n = "egrave";  16'd233: n = "eacute";
            16'd234: n = "ecirc";   16'd235: n = "euml";    16'd236: n = "igrave";
            16'd237: n = "iacute";  16'd238: n = "icirc";   16'd239: n = "iuml";
            16'd240: n = "eth";     16'd241: n = "ntilde";  16'd242: n = "ograve";
            16'd243: n = "oacute";  16'd244: n = "ocirc";   16'd245: n = "otilde";
            16'd246: n = "ouml";    16'd247: n = "divide";  16'd248: n = "oslash";
            16'd249: n = "ugrave";  16'd250: n = "uacute";  16'd251: n = "ucirc";
            16'd252: n = "uuml";    16'd253: n = "yacute";  16'd254: n = "thorn";
            16'd255: n = "yuml";    16'd305: n = "inodot";  16'd338: n = "OElig";
            16'd339: n = "oelig";   16'd352: n = "Scaron";  16'd353: n = "scaron";
            16'd376: n = "Yuml";    16'd402: n = "fnof";    16'd710: n = "circ";
            16'd711: n = "caron";   16'd728: n = "breve";   16'd729: n = "dot";
            16'd730: n = "ring";    16'd731: n = "ogon";    16'd732: n = "tilde";
            16'd733: n = "dblac";   16'd916: n = "Delta";   16'd931: n = "sum";
            16'd937: n = "Omega";   16'd960: n = "pi";      16'd8211: n = "ndash";
            16'd8212: n = "mdash";  16'd8216: n = "lsquo";  16'd8217: n = "rsquo";
            16'd8218: n = "lsquor"; 16'd8220: n = "ldquo";  16'd8221: n = "rdquo";
            16'd8222: n = "ldquor"; 16'd8224: n = "dagger"; 16'd8225: n = "Dagger";
            16'd8226: n = "bull";   16'd8230: n = "hellip"; 16'd8240: n = "permil";
            16'd8249: n = "lsaquo"; 16'd8250: n = "rsaquo"; 16'd8482: n = "trade";
            16'd8706: n = "part";   16'd8719: n = "prod";   16'd8730: n = "radic";
            16'd8734: n = "infin";  16'd8747: n = "int";    16'd8773: n = "ap";
            16'd8800: n = "ne";     16'd8804: n = "le";     16'd8805: n = "ge";
            16'd9674: n = "loz";
            default: n = '0;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/core/utf16_to_entity_encoder_top.sv
// ----------------------------------------------------------------------------
// utf16_to_entity_encoder_top
// Encodes UTF-16 code units as ASCII text with HTML character entities.
// ----------------------------------------------------------------------------
// Usage:
//   Input: an item transfers on a rising edge with start high and busy low.
//   mode selects encode (code_unit) or end of text (one zero byte).
//   Output: one byte per cycle on out_byte, marked by strobe; last_byte
//   flags the final byte of the run for an item. The receiver cannot
//   stall, so every strobe is a completed transfer.
//   Path: an item moves from the input register into the run buffer, then
//   its bytes pass through the output register to out_byte.
//   Throughput: an item producing N bytes holds the run buffer until its
//   N bytes are out (N = 1 for printable text, up to 8 for entities), so
//   printable text sustains one item per cycle. busy rises when the run
//   buffer has over one byte left and an item waits in the input register.
//   The decimal form uses four parallel reciprocal multiplies.
//   Reset: clears all valid flags and counts; no output until new input.
// ----------------------------------------------------------------------------
module utf16_to_entity_encoder_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        mode,
    input  logic [u2e_pkg::CodeW-1:0]   code_unit,
    output logic                        strobe,
    output logic [u2e_pkg::ByteW-1:0]   out_byte,
    output logic                        last_byte
);
    import u2e_pkg::*;

    logic             in_vld_reg;
    logic             in_mode_reg;
    logic [CodeW-1:0] in_code_reg;

    byte_t            run_buf_reg [RunMax];
    byte_t            run_buf_next [RunMax];
    logic [3:0]       run_len_reg;
    logic [3:0]       run_len_next;
    logic [2:0]       run_idx_reg;

    logic             strobe_reg;
    byte_t            out_byte_reg;
    logic             last_byte_reg;

    logic             move;
    logic             take;

    name_t            nm;
    logic [2:0]       nm_len;
    logic             printable;
    logic [32:0]      p1, p2, p3, p4;
    logic [15:0]      q1, q2, q3, q4;
    logic [3:0]       dg [DigitMax];
    logic [2:0]       nd;

    assign move = in_vld_reg && (run_len_reg <= 4'd1);
    assign busy = in_vld_reg && !move;
    assign take = start && !busy;

    always_comb
    begin
        nm     = name_lookup(in_code_reg);
        nm_len = '0;
        for (int k = 0; k < NameMax; k++)
        begin
            if (nm[k*ByteW +: ByteW] != ChNul)
                nm_len = 3'(k + 1);
        end
        p1 = 33'(in_code_reg) * 33'd104858;
        p2 = 33'(in_code_reg) * 33'd83887;
        p3 = 33'(in_code_reg) * 33'd67109;
        p4 = 33'(in_code_reg) * 33'd107375;
        q1 = 16'(p1 >> 20);
        q2 = 16'(p2 >> 23);
        q3 = 16'(p3 >> 26);
        q4 = 16'(p4 >> 30);
        dg[0] = 4'(in_code_reg - q1 * 16'd10);
        dg[1] = 4'(q1 - q2 * 16'd10);
        dg[2] = 4'(q2 - q3 * 16'd10);
        dg[3] = 4'(q3 - q4 * 16'd10);
        dg[4] = 4'(q4);
        if (in_code_reg >= 16'd10000)
            nd = 3'd5;
        else if (in_code_reg >= 16'd1000)
            nd = 3'd4;
        else if (in_code_reg >= 16'd100)
            nd = 3'd3;
        else if (in_code_reg >= 16'd10)
            nd = 3'd2;
        else
            nd = 3'd1;
        printable = (in_code_reg >= CodeLo && in_code_reg <= CodeHi)
                    || in_code_reg == CodeLf || in_code_reg == CodeCr;

        for (int j = 0; j < RunMax; j++)
            run_buf_next[j] = ChNul;
        run_len_next = 4'd1;
        if (in_mode_reg == MODE_END)
        begin
            run_buf_next[0] = ChNul;
            run_len_next    = 4'd1;
        end
        else if (printable)
        begin
            run_buf_next[0] = in_code_reg[ByteW-1:0];
            run_len_next    = 4'd1;
        end
        else if (nm_len != 3'd0)
        begin
            run_buf_next[0] = ChAmp;
            for (int k = 0; k < NameMax; k++)
            begin
                if (3'(k) < nm_len)
                    run_buf_next[k+1] = nm[(nm_len - 3'(k) - 3'd1)*ByteW +: ByteW];
            end
            run_buf_next[3'(nm_len + 3'd1)] = ChSemi;
            run_len_next = 4'(nm_len) + 4'd2;
        end
        else
        begin
            run_buf_next[0] = ChAmp;
            run_buf_next[1] = ChHash;
            for (int k = 0; k < DigitMax; k++)
            begin
                if (3'(k) < nd)
                    run_buf_next[k+2] = ChZero | {4'd0, dg[nd - 3'(k) - 3'd1]};
            end
            run_buf_next[3'(nd + 3'd2)] = ChSemi;
            run_len_next = 4'(nd) + 4'd3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            run_len_reg   <= '0;
            run_idx_reg   <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            if (take)
                in_vld_reg <= 1'b1;
            else if (move)
                in_vld_reg <= 1'b0;

            strobe_reg <= (run_len_reg != 4'd0);

            if (move)
            begin
                run_len_reg <= run_len_next;
                run_idx_reg <= '0;
            end
            else if (run_len_reg != 4'd0)
            begin
                run_len_reg <= run_len_reg - 4'd1;
                run_idx_reg <= run_idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_mode_reg <= mode;
            in_code_reg <= code_unit;
        end
        if (move)
            run_buf_reg <= run_buf_next;
        out_byte_reg  <= run_buf_reg[run_idx_reg];
        last_byte_reg <= (run_len_reg == 4'd1);
    end

    assign strobe    = strobe_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_byte_reg;

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Bench for the UTF-16 to HTML entity encoder: directed and random code
// units, byte runs predicted from a local entity table and checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import u2e_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             mode;
    logic [CodeW-1:0] code_unit;
    logic             strobe;
    logic [ByteW-1:0] out_byte;
    logic             last_byte;

    typedef struct packed {
        logic [ByteW-1:0] ch;
        logic             fin;
    } run_byte_t;

    run_byte_t   pending_bytes[$];
    int          mismatches;
    logic [15:0] named_codes[$];
    string       named_text[$];

    utf16_to_entity_encoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .code_unit (code_unit),
        .strobe    (strobe),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("[utf16_to_entity_encoder_top] ERROR");
        $finish;
    end

    function automatic void add_entity(input logic [15:0] c, input string s);
        named_codes.push_back(c);
        named_text.push_back(s);
    endfunction

    initial
    begin
        string words;
        string w;
        int    num;
        int    k;
        words = {
            "34 quot 38 amp 60 lt 62 gt 160 nbsp 161 iexcl 162 cent 163 pound ",
            "164 curren 165 yen 166 brvbar 167 sect 168 uml 169 copy 170 ordf ",
            "171 laquo 172 not 173 shy 174 reg 175 macr 176 deg 177 plusmn ",
            "178 sup2 179 sup3 180 acute 181 micro 182 para 183 middot 184 cedil ",
            "185 sup1 186 ordm 187 raquo 188 frac14 189 frac12 190 frac34 ",
            "191 iquest 192 Agrave 193 Aacute 194 Acirc 195 Atilde 196 Auml ",
            "197 Aring 198 AElig 199 Ccedil 200 Egrave 201 Eacute 202 Ecirc ",
            "203 Euml 204 Igrave 205 Iacute 206 Icirc 207 Iuml 208 ETH ",
            "209 Ntilde 210 Ograve 211 Oacute 212 Ocirc 213 Otilde 214 Ouml ",
            "215 times 216 Oslash 217 Ugrave 218 Uacute 219 Ucirc 220 Uuml ",
            "221 Yacute 222 THORN 223 szlig 224 agrave 225 aacute 226 acirc ",
            "227 atilde 228 auml 229 aring 230 aelig 231 ccedil 232 egrave ",
            "233 eacute 234 ecirc 235 euml 236 igrave 237 iacute 238 icirc ",
            "239 iuml 240 eth 241 ntilde 242 ograve 243 oacute 244 ocirc ",
            "245 otilde 246 ouml 247 divide 248 oslash 249 ugrave 250 uacute ",
            "251 ucirc 252 uuml 253 yacute 254 thorn 255 yuml 305 inodot ",
            "338 OElig 339 oelig 352 Scaron 353 scaron 376 Yuml 402 fnof ",
            "710 circ 711 caron 728 breve 729 dot 730 ring 731 ogon 732 tilde ",
            "733 dblac 916 Delta 931 sum 937 Omega 960 pi 8211 ndash 8212 mdash ",
            "8216 lsquo 8217 rsquo 8218 lsquor 8220 ldquo 8221 rdquo ",
            "8222 ldquor 8224 dagger 8225 Dagger 8226 bull 8230 hellip ",
            "8240 permil 8249 lsaquo 8250 rsaquo 8482 trade 8706 part ",
            "8719 prod 8730 radic 8734 infin 8747 int 8773 ap 8800 ne 8804 le ",
            "8805 ge 9674 loz "
        };
        k = 0;
        while (k < words.len())
        begin
            w = "";
            while (words[k] != " ")
            begin
                w = {w, words.substr(k, k)};
                k++;
            end
            k++;
            num = w.atoi();
            w = "";
            while (words[k] != " ")
            begin
                w = {w, words.substr(k, k)};
                k++;
            end
            k++;
            add_entity(num[15:0], w);
        end
    end

    function automatic string entity_name(input logic [15:0] c);
        foreach (named_codes[i])
            if (named_codes[i] == c)
                return named_text[i];
        return "";
    endfunction

    function automatic void predict_run(input logic m, input logic [15:0] c);
        string txt;
        string nm;
        if (m == MODE_END)
        begin
            pending_bytes.push_back('{ChNul, 1'b1});
            return;
        end
        if ((c >= CodeLo && c <= CodeHi) || c == CodeLf || c == CodeCr)
        begin
            pending_bytes.push_back('{c[7:0], 1'b1});
            return;
        end
        nm = entity_name(c);
        if (nm.len() != 0)
            txt = {"&", nm, ";"};
        else
            txt = $sformatf("&#%0d;", c);
        for (int i = 0; i < txt.len(); i++)
            pending_bytes.push_back('{txt[i], i == txt.len() - 1});
    endfunction

    always @(posedge clk)
    begin
        run_byte_t want;
        if (rst_n && strobe)
        begin
            if (pending_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected byte %h last %b", out_byte, last_byte);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (want.ch !== out_byte || want.fin !== last_byte)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("byte mismatch: expected %h/%b got %h/%b",
                                 want.ch, want.fin, out_byte, last_byte);
                end
            end
        end
    end

    // Leave start high on return; callers drop it before any gap.
    task automatic send_item(input logic m, input logic [15:0] c);
        start     <= 1'b1;
        mode      <= m;
        code_unit <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_run(m, c);
    endtask

    task automatic drain_runs();
        start <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic test_directed();
        logic [15:0] picks[$];
        picks = '{16'h0000, 16'hFFFF, 16'h0020, 16'h007E, 16'h001F, 16'h007F,
                  16'h000A, 16'h000D, 16'h0022, 16'h0026, 16'h003C, 16'h003E,
                  16'd160, 16'd177, 16'd9674, 16'd8773, 16'hD800, 16'hDFFF,
                  16'd10000, 16'd9999, 16'h5555, 16'hAAAA};
        foreach (picks[i])
            send_item(MODE_ENCODE, picks[i]);
        send_item(MODE_END, 16'hFFFF);
        send_item(MODE_END, 16'h0000);
        drain_runs();
    endtask

    task automatic test_random();
        int sent;
        int burst;
        logic [15:0] c;
        sent = 0;
        while (sent < 400)
        begin
            burst = $urandom_range(1, 20);
            repeat (burst)
            begin
                case ($urandom_range(0, 5))
                    0, 1: c = 16'($urandom_range(16'h20, 16'h7E));
                    2: c = named_codes[$urandom_range(0, named_codes.size() - 1)];
                    3: c = 16'($urandom_range(0, 31));
                    default: c = 16'($urandom);
                endcase
                send_item(($urandom_range(0, 15) == 0) ? MODE_END : MODE_ENCODE, c);
                sent++;
            end
            if (sent > 200 && sent < 220)
                drain_runs();
            if ($urandom_range(0, 2) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        mismatches = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        mode       = MODE_ENCODE;
        code_unit  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        drain_runs();
        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("[utf16_to_entity_encoder_top] OK");
        else
            $display("[utf16_to_entity_encoder_top] ERROR");
        $finish;
    end

endmodule
